/* rtl/core/layer_occlusion_test_macros.svh */
// Assertion macros shared by the occlusion test RTL.
`ifndef LAYER_OCCLUSION_TEST_MACROS_SVH
`define LAYER_OCCLUSION_TEST_MACROS_SVH

// Hold cons in the same cycle whenever ante is true.
`define LOC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("occlusion test assertion failed");

// Hold cons in the cycle after ante is true.
`define LOC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("occlusion test assertion failed");

`endif

/* rtl/core/loc_pkg.sv */
// Shared types and codes for the layer occlusion test.
package loc_pkg;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_INS   = 4'b0100,
      ST_SPARE = 4'b1000
   } loc_state_type;

   localparam logic OP_FIRST = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

endpackage

/* rtl/core/layer_occlusion_test.sv */
// Layer occlusion test top level: sequencer around the sorted occluder store.
// Rectangles arrive topmost first; each beat returns one visible/store_full
// result on a one-cycle rsp_valid strobe that the receiver cannot stall.
// busy is high while an item is at work. An opcode-0 non-opaque beat answers
// straight from the idle state; an opcode-0 opaque beat answers after it is
// written as the first entry of the store. An opcode-1 beat sweeps the stored
// occluders through the single read port, one entry a cycle, and a visible
// opaque rectangle then shifts the entries with a larger left edge up and is
// inserted. The next beat may already be accepted at the edge that ends an
// item's result strobe. The store needs no clearing after reset.
module layer_occlusion_test #(
   parameter int MAX_RECTS  = 32,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic signed [15:0] req_rect_left,
   input  logic signed [15:0] req_rect_top,
   input  logic signed [15:0] req_rect_right,
   input  logic signed [15:0] req_rect_bottom,
   input  logic               req_is_opaque,
   output logic               rsp_valid,
   output logic               rsp_visible,
   output logic               rsp_store_full
);
   import loc_pkg::*;
   `include "layer_occlusion_test_macros.svh"

   localparam int CW = COORD_BITS;
   localparam int EW = 4 * CW;
   localparam int AW = $clog2(MAX_RECTS);
   localparam int NW = $clog2(MAX_RECTS + 1);

   loc_state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic          opaque_ff, opaque_in;
   logic signed [CW-1:0] run_ff, run_in;
   logic signed [CW-1:0] left_ff, left_in, top_ff, top_in;
   logic signed [CW-1:0] right_ff, right_in, bottom_ff, bottom_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_visible_ff, rsp_visible_in;
   logic rsp_store_full_ff, rsp_store_full_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic signed [CW-1:0] d_left, d_top, d_right, d_bottom;
   logic [NW-1:0] pos_m1, pos_m2, count_m1;
   logic          decided, vis_dec, ext;

   loc_store #(.DEPTH(MAX_RECTS), .WIDTH(EW), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign d_left   = rd_data[CW-1:0];
   assign d_top    = rd_data[2*CW-1:CW];
   assign d_right  = rd_data[3*CW-1:2*CW];
   assign d_bottom = rd_data[4*CW-1:3*CW];
   assign pos_m1   = pos_ff - NW'(1);
   assign pos_m2   = pos_ff - NW'(2);
   assign count_m1 = count_ff - NW'(1);
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      idx_in            = idx_ff;
      pos_in            = pos_ff;
      pend_in           = pend_ff;
      opaque_in         = opaque_ff;
      run_in            = run_ff;
      left_in           = left_ff;
      top_in            = top_ff;
      right_in          = right_ff;
      bottom_in         = bottom_ff;
      rsp_valid_in      = 1'b0;
      rsp_visible_in    = rsp_visible_ff;
      rsp_store_full_in = rsp_store_full_ff;
      wr_en             = 1'b0;
      wr_addr           = pos_ff[AW-1:0];
      wr_data           = {bottom_ff, right_ff, top_ff, left_ff};
      rd_addr           = idx_ff[AW-1:0];
      decided           = 1'b0;
      vis_dec           = 1'b1;
      ext               = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               left_in   = CW'(req_rect_left);
               top_in    = CW'(req_rect_top);
               right_in  = CW'(req_rect_right);
               bottom_in = CW'(req_rect_bottom);
               run_in    = CW'(req_rect_left);
               opaque_in = req_is_opaque;
               idx_in    = '0;
               pend_in   = 1'b0;
               if (req_opcode == OP_FIRST) begin
                  count_in = '0;
                  pos_in   = '0;
                  if (req_is_opaque) begin
                     state_in = ST_INS;
                  end else begin
                     rsp_valid_in      = 1'b1;
                     rsp_visible_in    = 1'b1;
                     rsp_store_full_in = 1'b0;
                  end
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (pend_ff) begin
               if (run_ff < d_left) begin
                  decided = 1'b1;
                  vis_dec = 1'b1;
               end else if (run_ff < d_right && d_top <= top_ff && bottom_ff <= d_bottom) begin
                  ext    = 1'b1;
                  run_in = d_right;
                  if (d_right >= right_ff) begin
                     decided = 1'b1;
                     vis_dec = 1'b0;
                  end
               end
            end
            if (!decided) begin
               if (idx_ff < count_ff) begin
                  pend_in = 1'b1;
                  idx_in  = idx_ff + NW'(1);
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     decided = 1'b1;
                     vis_dec = 1'b1;
                  end
               end
            end
            if (decided) begin
               if (vis_dec && opaque_ff) begin
                  if (count_ff == NW'(MAX_RECTS)) begin
                     state_in          = ST_IDLE;
                     rsp_valid_in      = 1'b1;
                     rsp_visible_in    = 1'b1;
                     rsp_store_full_in = 1'b1;
                  end else begin
                     pos_in   = count_ff;
                     rd_addr  = count_m1[AW-1:0];
                     state_in = ST_INS;
                  end
               end else begin
                  state_in          = ST_IDLE;
                  rsp_valid_in      = 1'b1;
                  rsp_visible_in    = vis_dec;
                  rsp_store_full_in = 1'b0;
               end
            end
         end
         ST_INS: begin
            wr_en = 1'b1;
            if (pos_ff != '0 && d_left > left_ff) begin
               wr_data = rd_data;
               pos_in  = pos_m1;
               rd_addr = pos_m2[AW-1:0];
            end else begin
               count_in          = count_ff + NW'(1);
               state_in          = ST_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_visible_in    = 1'b1;
               rsp_store_full_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff            <= idx_in;
      pos_ff            <= pos_in;
      opaque_ff         <= opaque_in;
      run_ff            <= run_in;
      left_ff           <= left_in;
      top_ff            <= top_in;
      right_ff          <= right_in;
      bottom_ff         <= bottom_in;
      rsp_visible_ff    <= rsp_visible_in;
      rsp_store_full_ff <= rsp_store_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_visible    = rsp_visible_ff;
   assign rsp_store_full = rsp_store_full_ff;

   `LOC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= NW'(MAX_RECTS))
   `LOC_ASSERT_SAME(a_full_is_visible, clock, reset, rsp_valid_ff && rsp_store_full_ff,
                    rsp_visible_ff)
   `LOC_ASSERT_SAME(a_beat_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `LOC_ASSERT_NEXT(a_insert_grows, clock, reset, state_ff == ST_INS && state_in == ST_IDLE,
                    count_ff == $past(count_ff) + NW'(1))
endmodule

/* rtl/core/loc_store.sv */
// Occluder store: one write port, one registered read port.
module loc_store #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
